// File: hdl/ssm_pkg.sv
// Shared types and constants for the spherical soft mask block.
// No dependencies; used by the channel interfaces and all hdl modules.
package ssm_pkg;

  localparam int COORD_W   = 12;
  localparam int CENTER_W  = 22;
  localparam int LEN_W     = 20;
  localparam int SAMPLE_W  = 32;
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 22;

  localparam logic [MASK_W-1:0] MASK_ONE = 16'd32768;
  localparam longint ROUND_HALF = 64'sd16384;
  localparam int MASK_SHIFT = 15;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CENTER_X   = 3'd0,
    CFG_CENTER_Y   = 3'd1,
    CFG_CENTER_Z   = 3'd2,
    CFG_RADIUS     = 3'd3,
    CFG_TAPER      = 3'd4,
    CFG_INVERT     = 3'd5,
    CFG_THREE_DIMS = 3'd6
  } cfg_idx_e;

  // Where a voxel falls relative to the sphere
  typedef enum logic [1:0] {
    CLS_ZERO,
    CLS_ONE,
    CLS_EDGE
  } cls_e;

  // Sideband that rides along the pipeline with each transaction
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    cls_e                       cls;
    logic                       cap;
  } meta_t;

endpackage

// File: hdl/ssm_channels.sv
// Valid/ready channel interfaces: voxel input, masked result, register write.
// Depends on ssm_pkg for field widths.
interface ssm_in_if import ssm_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic [COORD_W-1:0]         coord_x;
  logic [COORD_W-1:0]         coord_y;
  logic [COORD_W-1:0]         coord_z;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, coord_x, coord_y, coord_z, sample_value, input ready);
  modport sink   (input valid, coord_x, coord_y, coord_z, sample_value, output ready);
endinterface

interface ssm_out_if import ssm_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] masked_value;
  logic [MASK_W-1:0]          mask_weight;

  modport source (output valid, masked_value, mask_weight, input ready);
  modport sink   (input valid, masked_value, mask_weight, output ready);
endinterface

interface ssm_cfg_if import ssm_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DAT_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/ssm_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on ssm_pkg for the sideband struct.
module ssm_isqrt import ssm_pkg::*; #(
  parameter int D2W = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [D2W-1:0]       rad_i,
  input  meta_t                meta_i,
  output logic                 valid_o,
  output logic [D2W/2-1:0]     root_o,
  output meta_t                meta_o
);

  localparam int Steps = D2W / 2;

  logic [D2W-1:0] v_q [Steps+1];
  logic [D2W-1:0] r_q [Steps+1];
  meta_t          m_q [Steps+1];
  logic [Steps:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_q[0] <= rad_i;
      r_q[0] <= '0;
      m_q[0] <= meta_i;
    end
  end

  for (genvar k = 0; k < Steps; k++) begin : g_step
    localparam logic [D2W:0] Bit = (D2W+1)'(1) << (2 * (Steps - 1 - k));
    logic [D2W:0]   sum;
    logic           take;
    logic [D2W-1:0] v_d;
    logic [D2W-1:0] r_d;

    always_comb begin
      sum  = {1'b0, r_q[k]} + Bit;
      take = ({1'b0, v_q[k]} >= sum);
      v_d  = take ? D2W'({1'b0, v_q[k]} - sum) : v_q[k];
      r_d  = take ? D2W'(({1'b0, r_q[k]} >> 1) + Bit) : (r_q[k] >> 1);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        v_q[k+1] <= v_d;
        r_q[k+1] <= r_d;
        m_q[k+1] <= m_q[k];
      end
    end
  end

  assign valid_o = vld_q[Steps];
  assign root_o  = r_q[Steps][Steps-1:0];
  assign meta_o  = m_q[Steps];

endmodule

// File: hdl/ssm_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on ssm_pkg; numerator must give a quotient below 2**QW.
module ssm_div import ssm_pkg::*; #(
  parameter int NW = 31,
  parameter int DW = 20,
  parameter int QW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] div_i,
  input  meta_t         meta_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o,
  output meta_t         meta_o
);

  logic [DW-1:0] rem_q [QW+1];
  logic [QW-1:0] q_q   [QW+1];
  meta_t         m_q   [QW+1];
  logic [QW:0]   vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  // high part is already below the divisor, low bits feed in one per step
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= DW'(num_i >> QW);
      q_q[0]   <= num_i[QW-1:0];
      m_q[0]   <= meta_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0]   t;
    logic          ge;
    logic [DW-1:0] rem_d;

    always_comb begin
      t     = {rem_q[k], q_q[k][QW-1]};
      ge    = (t >= {1'b0, div_i});
      rem_d = ge ? DW'(t - {1'b0, div_i}) : DW'(t);
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k+1] <= rem_d;
        q_q[k+1]   <= {q_q[k][QW-2:0], ge};
        m_q[k+1]   <= m_q[k];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign quo_o   = q_q[QW];
  assign meta_o  = m_q[QW];

endmodule

// File: hdl/spherical_soft_mask.sv
// Spherical soft mask: top level, stage registers, edge weight ROM, products.
// Depends on ssm_pkg, ssm_channels (interfaces), ssm_isqrt and ssm_div.
//
// Usage:
//  voxel_i carries one voxel per transaction: integer coords and a signed sample.
//  result_o returns one transaction per voxel, in order: the sample times the
//  mask (Q1.15, rounded, halves up) and the mask itself.
//  cfg_i writes the seven registers by index (center x/y/z, radius, taper width,
//  invert, three_dims). Writes are taken every cycle; only write while the
//  pipeline is empty. Squared radius terms are registered from the radius and
//  taper registers, so they settle after those registers take a write.
//  Throughput: one voxel per cycle while the result register is not held;
//  voxels pass the root pipeline (one bit per stage) and the phase divider.
//  The whole pipeline advances on one enable: when the result register holds
//  an unaccepted transaction, voxel_i.ready drops and every stage holds its
//  contents, so nothing is dropped or repeated. Bubbles flow as invalid stages.
//  Reset clears all valid bits and loads the register reset values
//  (three_dims set, everything else zero).
module spherical_soft_mask import ssm_pkg::*; #(
  parameter int MAX_EXTENT        = 4096,
  parameter int COS_TABLE_ENTRIES = 1024,
  parameter int FRAC_BITS         = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ssm_in_if.sink    voxel_i,
  ssm_out_if.source result_o,
  ssm_cfg_if.sink   cfg_i
);

  // Datapath widths
  localparam int PosW = COORD_W + FRAC_BITS;
  localparam int DxW  = ((PosW + 1 > CENTER_W) ? PosW + 1 : CENTER_W) + 1;
  localparam int SqW  = 2 * DxW;
  localparam int D2W  = SqW + 2;
  localparam int RtW  = D2W / 2;
  localparam int IW   = $clog2(COS_TABLE_ENTRIES + 1);
  localparam int QW   = $clog2(COS_TABLE_ENTRIES);
  localparam int NW   = LEN_W + IW;
  localparam int ProdW = SAMPLE_W + MASK_W + 1;

  // Edge weight (1+cos(pi*i/N))/2 in Q1.15, built at elaboration
  typedef logic [MASK_W-1:0] rom_t [0:COS_TABLE_ENTRIES];

  // shift-subtract quotient, elaboration use only
  function automatic longint unsigned udiv_f(longint unsigned n, longint unsigned d);
    longint unsigned rem;
    longint unsigned quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], n[b]};
      if (rem >= d) begin
        rem    = rem - d;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic rom_t build_rom_f();
    rom_t              rom;
    logic              flip;
    longint unsigned   mm;
    longint            a;
    longint            a2;
    longint            term;
    longint            dv;
    longint            vv;
    longint            prod;
    longint unsigned   mag;
    longint            qt;
    for (int i = 0; i <= COS_TABLE_ENTRIES; i++) begin
      flip = (2 * i > COS_TABLE_ENTRIES);
      mm   = flip ? longint'(COS_TABLE_ENTRIES - i) : longint'(i);
      a    = longint'(udiv_f(PI_Q30 * mm, 64'(COS_TABLE_ENTRIES)));
      a2   = longint'((longint'(unsigned'(a)) * a) >>> 30);
      term = ONE_Q30;
      for (int k = 7; k >= 1; k--) begin
        dv   = longint'((2 * k - 1) * (2 * k));
        // truncating toward zero
        prod = a2 * term;
        mag  = unsigned'((prod < 0) ? -prod : prod);
        qt   = longint'(udiv_f(mag, unsigned'(dv) << 30));
        term = ONE_Q30 - ((prod < 0) ? -qt : qt);
      end
      if (term < 0) term = 0;
      if (term > ONE_Q30) term = ONE_Q30;
      vv = flip ? ONE_Q30 - term : ONE_Q30 + term;
      rom[i] = MASK_W'((vv + 64'sd32768) >>> 16);
    end
    return rom;
  endfunction

  localparam rom_t WeightRom = build_rom_f();

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic signed [CENTER_W-1:0] center_x_q, center_y_q, center_z_q;
  logic [LEN_W-1:0]           radius_q, taper_q;
  logic                       invert_q, three_dims_q;
  logic [2*LEN_W-1:0]         r2_q;
  logic [2*LEN_W+1:0]         rt2_q;
  logic [LEN_W:0]             rt_sum;

  assign cfg_i.ready = 1'b1;
  assign rt_sum = {1'b0, radius_q} + {1'b0, taper_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q   <= '0;
      center_y_q   <= '0;
      center_z_q   <= '0;
      radius_q     <= '0;
      taper_q      <= '0;
      invert_q     <= 1'b0;
      three_dims_q <= 1'b1;
      r2_q         <= '0;
      rt2_q        <= '0;
    end else begin
      // squared thresholds are registered from the radius and taper registers
      r2_q  <= radius_q * radius_q;
      rt2_q <= rt_sum * rt_sum;
      if (cfg_i.valid) begin
        unique case (cfg_idx_e'(cfg_i.index))
          CFG_CENTER_X:   center_x_q   <= cfg_i.data;
          CFG_CENTER_Y:   center_y_q   <= cfg_i.data;
          CFG_CENTER_Z:   center_z_q   <= cfg_i.data;
          CFG_RADIUS:     radius_q     <= cfg_i.data[LEN_W-1:0];
          CFG_TAPER:      taper_q      <= cfg_i.data[LEN_W-1:0];
          CFG_INVERT:     invert_q     <= cfg_i.data[0];
          CFG_THREE_DIMS: three_dims_q <= cfg_i.data[0];
          default: ;
        endcase
      end
    end
  end

  // Global advance: every stage moves unless the result is held
  logic en;
  assign en = !result_o.valid || result_o.ready;
  assign voxel_i.ready = en;

  // ---------------------------------------------------------------------------
  // Stage 1: offsets from center in fixed point
  // ---------------------------------------------------------------------------
  function automatic logic signed [DxW-1:0] axis_f(logic [COORD_W-1:0] c,
                                                   logic signed [CENTER_W-1:0] ctr);
    logic [COORD_W-1:0] q;
    logic [PosW-1:0]    pos;
    q   = (32'(c) >= MAX_EXTENT) ? COORD_W'(MAX_EXTENT - 1) : c;
    pos = PosW'(q) << FRAC_BITS;
    return DxW'($signed({1'b0, pos})) - DxW'(ctr);
  endfunction

  logic                  s1_vld_q;
  logic signed [DxW-1:0] dx_q, dy_q, dz_q;
  meta_t                 s1_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (en) begin
      s1_vld_q <= voxel_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dx_q <= axis_f(voxel_i.coord_x, center_x_q);
      dy_q <= axis_f(voxel_i.coord_y, center_y_q);
      dz_q <= axis_f(voxel_i.coord_z, center_z_q);
      s1_meta_q <= '{sample: voxel_i.sample_value, cls: CLS_ZERO, cap: 1'b0};
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: squares; z drops out in 2D mode
  // ---------------------------------------------------------------------------
  logic                  s2_vld_q;
  logic [SqW-1:0]        sx_q, sy_q, sz_q;
  meta_t                 s2_meta_q;
  logic signed [SqW-1:0] px, py, pz;

  assign px = dx_q * dx_q;
  assign py = dy_q * dy_q;
  assign pz = dz_q * dz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (en) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q <= $unsigned(px);
      sy_q <= $unsigned(py);
      sz_q <= three_dims_q ? $unsigned(pz) : '0;
      s2_meta_q <= s1_meta_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: squared distance
  // ---------------------------------------------------------------------------
  logic           s3_vld_q;
  logic [D2W-1:0] d2_q;
  meta_t          s3_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (en) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q <= D2W'(sx_q) + D2W'(sy_q) + D2W'(sz_q);
      s3_meta_q <= s2_meta_q;
    end
  end

  // Region: hard edge uses the inner compare only
  logic  in_sphere, outside;
  meta_t cls_meta;

  always_comb begin
    in_sphere = (d2_q <= D2W'(r2_q));
    outside   = (d2_q > D2W'(rt2_q));
    cls_meta  = s3_meta_q;
    if (taper_q == '0) begin
      cls_meta.cls = in_sphere ? CLS_ONE : CLS_ZERO;
    end else if (outside) begin
      cls_meta.cls = CLS_ZERO;
    end else if (in_sphere) begin
      cls_meta.cls = CLS_ONE;
    end else begin
      cls_meta.cls = CLS_EDGE;
    end
  end

  // ---------------------------------------------------------------------------
  // Root of the squared distance
  // ---------------------------------------------------------------------------
  logic           sq_vld;
  logic [RtW-1:0] root;
  meta_t          sq_meta;

  ssm_isqrt #(.D2W(D2W)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s3_vld_q),
    .rad_i   (d2_q),
    .meta_i  (cls_meta),
    .valid_o (sq_vld),
    .root_o  (root),
    .meta_o  (sq_meta)
  );

  // ---------------------------------------------------------------------------
  // Stage 5: distance past the radius; cap when a full taper width is reached
  // ---------------------------------------------------------------------------
  logic             s5_vld_q;
  logic [LEN_W-1:0] diff_q;
  meta_t            s5_meta_q;
  meta_t            s5_meta_d;
  logic [RtW-1:0]   diff_full;

  assign diff_full = (root > RtW'(radius_q)) ? root - RtW'(radius_q) : '0;

  always_comb begin
    s5_meta_d     = sq_meta;
    s5_meta_d.cap = (diff_full >= RtW'(taper_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (en) begin
      s5_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      diff_q    <= diff_full[LEN_W-1:0];
      s5_meta_q <= s5_meta_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: scale by table size ahead of the divide
  // ---------------------------------------------------------------------------
  logic          s6_vld_q;
  logic [NW-1:0] num_q;
  meta_t         s6_meta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (en) begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      num_q <= NW'(diff_q) * NW'(COS_TABLE_ENTRIES);
      s6_meta_q <= s5_meta_q;
    end
  end

  // Phase index = scaled distance / taper width
  logic          dv_vld;
  logic [QW-1:0] quo;
  meta_t         dv_meta;

  ssm_div #(.NW(NW), .DW(LEN_W), .QW(QW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s6_vld_q),
    .num_i   (num_q),
    .div_i   (taper_q),
    .meta_i  (s6_meta_q),
    .valid_o (dv_vld),
    .quo_o   (quo),
    .meta_o  (dv_meta)
  );

  // ---------------------------------------------------------------------------
  // Stage 7: weight ROM read
  // ---------------------------------------------------------------------------
  logic              s7_vld_q;
  logic [MASK_W-1:0] weight_q;
  meta_t             s7_meta_q;
  logic [IW-1:0]     rom_idx;

  assign rom_idx = dv_meta.cap ? IW'(COS_TABLE_ENTRIES) : IW'(quo);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (en) begin
      s7_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      weight_q  <= WeightRom[rom_idx];
      s7_meta_q <= dv_meta;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: mask select and invert
  // ---------------------------------------------------------------------------
  logic              s8_vld_q;
  logic [MASK_W-1:0] mask_q;
  meta_t             s8_meta_q;
  logic [MASK_W-1:0] mask_sel;

  always_comb begin
    case (s7_meta_q.cls)
      CLS_ONE:  mask_sel = MASK_ONE;
      CLS_EDGE: mask_sel = weight_q;
      default:  mask_sel = '0;
    endcase
    if (invert_q) mask_sel = MASK_ONE - mask_sel;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
    end else if (en) begin
      s8_vld_q <= s7_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mask_q    <= mask_sel;
      s8_meta_q <= s7_meta_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: sample times mask
  // ---------------------------------------------------------------------------
  logic                    s9_vld_q;
  logic signed [ProdW-1:0] prod_q;
  logic [MASK_W-1:0]       s9_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s9_vld_q <= 1'b0;
    end else if (en) begin
      s9_vld_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q    <= ProdW'(s8_meta_q.sample) * $signed({1'b0, mask_q});
      s9_mask_q <= mask_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 10: round (floor of p + half) into the result register
  // ---------------------------------------------------------------------------
  logic                    out_vld_q;
  logic signed [ProdW-1:0] rounded;

  assign rounded = (prod_q + ProdW'(ROUND_HALF)) >>> MASK_SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= s9_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      result_o.masked_value <= rounded[SAMPLE_W-1:0];
      result_o.mask_weight  <= s9_mask_q;
    end
  end

  assign result_o.valid = out_vld_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_mask_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.mask_weight <= MASK_ONE))
    else $error("mask above one");

  a_zero_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.mask_weight == '0) |-> (result_o.masked_value == '0))
    else $error("nonzero product under zero mask");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready) |-> !voxel_i.ready)
    else $error("input taken while result held");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && !result_o.ready) |=>
      (result_o.valid && $stable(result_o.mask_weight) && $stable(s9_vld_q)))
    else $error("pipeline moved during stall");

endmodule

// File: dv/ssm_tb_channels.sv
// Testbench-side note file: channel interfaces come from hdl/ssm_channels.sv.
// Depends on ssm_pkg; holds the voxel and result item types used by the testbench.
`timescale 1ns / 100ps
package ssm_tb_pkg;
  import ssm_pkg::*;

  typedef struct {
    logic [COORD_W-1:0]         cx;
    logic [COORD_W-1:0]         cy;
    logic [COORD_W-1:0]         cz;
    logic signed [SAMPLE_W-1:0] sample;
  } voxel_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] masked;
    logic [MASK_W-1:0]          mask;
  } masked_t;
endpackage

// File: dv/testbench.sv
// Testbench for spherical_soft_mask: directed and random voxels, checked
// against an in-bench mask predictor. Depends on ssm_pkg, ssm_channels, ssm_tb_pkg.
`timescale 1ns / 100ps
module testbench;
  import ssm_pkg::*;
  import ssm_tb_pkg::*;

  localparam int EXTENT  = 4096;
  localparam int N_COS   = 1024;
  localparam int FRAC    = 8;
  localparam int LATENCY = 45;
  localparam int WDOG    = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ssm_in_if  voxel_if ();
  ssm_out_if result_if ();
  ssm_cfg_if cfg_if ();

  spherical_soft_mask i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .voxel_i  (voxel_if.sink),
    .result_o (result_if.source),
    .cfg_i    (cfg_if.sink)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // predictor copy of the registers
  longint           m_cx, m_cy, m_cz;
  longint unsigned  m_rad, m_taper;
  bit               m_inv, m_3d;

  voxel_t  pending_voxels[$];
  masked_t expected_results[$];
  int      errors = 0;
  int      n_checked = 0;
  int      send_idle = 0, recv_idle = 0;  // percent
  bit      hold_send = 1'b0;
  int      quiet_cycles = 0;

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // raised cosine weight (1+cos(pi*i/N))/2 in Q1.15
  function automatic logic [MASK_W-1:0] cos_weight(longint unsigned i);
    bit     flip;
    longint unsigned m;
    longint a, a2, term, v;
    flip = (2 * i > N_COS);
    m = flip ? N_COS - i : i;
    a = longint'((PI_Q30 * m) / N_COS);
    a2 = longint'((unsigned'(a) * unsigned'(a)) >> 30);
    term = ONE_Q30;
    for (int k = 7; k >= 1; k--)
      term = ONE_Q30 - (a2 * term) / (longint'((2 * k - 1) * (2 * k)) * ONE_Q30);
    if (term < 0) term = 0;
    if (term > ONE_Q30) term = ONE_Q30;
    v = flip ? ONE_Q30 - term : ONE_Q30 + term;
    return MASK_W'(unsigned'(v + 32768) >> 16);
  endfunction

  function automatic longint axis_offset(logic [COORD_W-1:0] c, longint ctr);
    longint unsigned q;
    q = c;
    if (q >= EXTENT) q = EXTENT - 1;
    return longint'(q << FRAC) - ctr;
  endfunction

  function automatic masked_t predict_mask(voxel_t vx);
    masked_t r;
    longint dx, dy, dz, p;
    longint unsigned d2, r2, rt2, d, diff, i;
    logic [MASK_W-1:0] mk;
    dx = axis_offset(vx.cx, m_cx);
    dy = axis_offset(vx.cy, m_cy);
    dz = axis_offset(vx.cz, m_cz);
    d2 = unsigned'(dx * dx) + unsigned'(dy * dy);
    if (m_3d) d2 += unsigned'(dz * dz);
    r2 = m_rad * m_rad;
    if (m_taper == 0) begin
      mk = (d2 <= r2) ? MASK_ONE : '0;
    end else begin
      rt2 = (m_rad + m_taper) * (m_rad + m_taper);
      if (d2 > rt2) mk = '0;
      else if (d2 <= r2) mk = MASK_ONE;
      else begin
        d = int_sqrt(d2);
        diff = (d > m_rad) ? d - m_rad : 0;
        i = (diff * N_COS) / m_taper;
        if (i > N_COS) i = N_COS;
        mk = cos_weight(i);
      end
    end
    if (m_inv) mk = MASK_ONE - mk;
    p = longint'(vx.sample) * longint'(mk) + ROUND_HALF;
    r.masked = SAMPLE_W'(p >>> MASK_SHIFT);  // arithmetic shift = floor
    r.mask = mk;
    return r;
  endfunction

  // --- driver: voxel channel
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      voxel_if.valid <= 1'b0;
      voxel_if.coord_x <= '0;
      voxel_if.coord_y <= '0;
      voxel_if.coord_z <= '0;
      voxel_if.sample_value <= '0;
    end else begin
      if (!voxel_if.valid || voxel_if.ready) begin
        // current transaction done (or none); load next or idle
        if (voxel_if.valid && voxel_if.ready)
          expected_results.push_back(predict_mask(pending_voxels.pop_front()));
        if (pending_voxels.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle) begin
          voxel_if.valid <= 1'b1;
          voxel_if.coord_x <= pending_voxels[0].cx;
          voxel_if.coord_y <= pending_voxels[0].cy;
          voxel_if.coord_z <= pending_voxels[0].cz;
          voxel_if.sample_value <= pending_voxels[0].sample;
        end else begin
          voxel_if.valid <= 1'b0;
        end
      end
    end
  end

  // --- monitor: result channel, with random back-pressure
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_if.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (result_if.valid && result_if.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing expected: masked_value %0d",
                 result_if.masked_value);
          errors++;
        end else begin
          masked_t e;
          e = expected_results.pop_front();
          if (result_if.masked_value !== e.masked) begin
            $error("masked_value expected %0d actual %0d", e.masked, result_if.masked_value);
            errors++;
          end
          if (result_if.mask_weight !== e.mask) begin
            $error("mask_weight expected %0d actual %0d", e.mask, result_if.mask_weight);
            errors++;
          end
          n_checked++;
        end
      end
      result_if.ready <= ($urandom_range(99) >= recv_idle);
      if ((voxel_if.valid && voxel_if.ready) || (result_if.valid && result_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(posedge clk_i) begin
    if (quiet_cycles >= WDOG) begin
      $display("watchdog: no transaction for %0d cycles", WDOG);
      $display("Test completed with failures");
      $finish;
    end
  end

  // wait until every queued voxel is accepted and every result checked
  task automatic drain();
    while (pending_voxels.size() > 0 || voxel_if.valid || expected_results.size() > 0)
      @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  // single register write; predictor copy updated on acceptance
  task automatic write_reg(cfg_idx_e idx, logic [CFG_DAT_W-1:0] val);
    cfg_if.index <= idx;
    cfg_if.data <= val;
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_CENTER_X:   m_cx = longint'(signed'(val));
      CFG_CENTER_Y:   m_cy = longint'(signed'(val));
      CFG_CENTER_Z:   m_cz = longint'(signed'(val));
      CFG_RADIUS:     m_rad = val[LEN_W-1:0];
      CFG_TAPER:      m_taper = val[LEN_W-1:0];
      CFG_INVERT:     m_inv = val[0];
      CFG_THREE_DIMS: m_3d = val[0];
      default: ;
    endcase
    @(posedge clk_i);  // squared terms settle
  endtask

  task automatic set_sphere(longint cx, longint cy, longint cz, int rad, int tap,
                            bit inv, bit d3);
    write_reg(CFG_CENTER_X, CFG_DAT_W'(cx));
    write_reg(CFG_CENTER_Y, CFG_DAT_W'(cy));
    write_reg(CFG_CENTER_Z, CFG_DAT_W'(cz));
    write_reg(CFG_RADIUS, CFG_DAT_W'(rad));
    write_reg(CFG_TAPER, CFG_DAT_W'(tap));
    write_reg(CFG_INVERT, CFG_DAT_W'(inv));
    write_reg(CFG_THREE_DIMS, CFG_DAT_W'(d3));
  endtask

  task automatic push_voxel(int x, int y, int z, logic [31:0] s);
    voxel_t v;
    v.cx = COORD_W'(x); v.cy = COORD_W'(y); v.cz = COORD_W'(z); v.sample = s;
    pending_voxels.push_back(v);
  endtask

  // random sample: half the time near an extreme, otherwise small or full-range
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(3))
      0: return 32'h8000_0000 | $urandom_range(1);
      1: return 32'h7fff_ffff - $urandom_range(1);
      2: return 32'($signed($urandom_range(65536)) - 32768);
      default: return $urandom();
    endcase
  endfunction

  // random voxels, mostly near the programmed shell so edge weights are exercised
  task automatic push_random(int count);
    int rr, x, y, z;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(4) == 0) begin
        x = $urandom_range(4095); y = $urandom_range(4095); z = $urandom_range(4095);
      end else begin
        rr = int'((m_rad + m_taper) >> FRAC) + 2;
        x = int'(m_cx >>> FRAC) + $signed($urandom_range(2 * rr)) - rr;
        y = int'(m_cy >>> FRAC) + $signed($urandom_range(2 * rr)) - rr;
        z = int'(m_cz >>> FRAC) + $signed($urandom_range(2 * rr)) - rr;
        x = x < 0 ? 0 : (x > 4095 ? 4095 : x);
        y = y < 0 ? 0 : (y > 4095 ? 4095 : y);
        z = z < 0 ? 0 : (z > 4095 ? 4095 : z);
      end
      push_voxel(x, y, z, rand_sample());
    end
  endtask

  initial begin
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data = '0;
    m_cx = 0; m_cy = 0; m_cz = 0; m_rad = 0; m_taper = 0; m_inv = 0; m_3d = 1;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset values: hard edge of radius zero at origin
    push_voxel(0, 0, 0, 32'h7fff_ffff);
    push_voxel(1, 0, 0, 32'h8000_0000);
    drain();

    // directed: soft edge, centre 10.5
    set_sphere(10 * 256 + 128, 2688, 2688, 5 * 256, 4 * 256, 0, 1);
    push_voxel(10, 10, 10, 32'h8000_0000);        // inside
    push_voxel(10, 10, 16, 32'h7fff_ffff);        // edge
    push_voxel(10, 10, 17, -32'sd3);              // edge
    push_voxel(10, 10, 19, 32'd12345);            // near outer
    push_voxel(4095, 4095, 4095, 32'hffff_ffff);  // far outside
    push_voxel(10, 10, 4095, 32'd1);
    push_voxel(17, 12, 12, 32'hffff_c000);        // half rounding cases
    drain();
    // invert, 2D: z ignored
    set_sphere(10 * 256, 2560, -1048576, 5 * 256, 4 * 256, 1, 0);
    push_voxel(10, 10, 4095, 32'h7fff_ffff);
    push_voxel(10, 16, 0, 32'h8000_0000);
    push_voxel(4095, 0, 0, -32'sd1);
    // sender holds the next voxel until every result is in
    while (pending_voxels.size() > 0 || voxel_if.valid) @(posedge clk_i);
    hold_send = 1'b1;
    push_voxel(14, 13, 7, 32'h0000_4000);
    while (expected_results.size() > 0) @(posedge clk_i);
    hold_send = 1'b0;
    drain();
    // extremes: max centre, max radius/taper
    set_sphere(2097151, -1048576, 0, 1048575, 1048575, 0, 1);
    push_voxel(4095, 0, 0, 32'h7fff_ffff);
    push_voxel(0, 4095, 4095, 32'h8000_0000);
    push_voxel(2048, 2048, 2048, 32'h5555_5555);
    drain();
    // hard edge, small radius
    set_sphere(-1, 2047, 3000, 3, 0, 0, 1);
    push_voxel(0, 8, 12, -32'sd16385);
    push_voxel(0, 8, 11, 32'd16385);
    drain();

    // random phases over several settings and idling profiles
    for (int ph = 0; ph < 12; ph++) begin
      if (ph < 4) begin send_idle = 31; recv_idle = 68; end
      else if (ph < 8) begin send_idle = 68; recv_idle = 31; end
      else begin send_idle = 0; recv_idle = 0; end
      set_sphere($signed($urandom_range(2048 * 256)) + $signed($urandom_range(1)) * 0 -
                   $signed($urandom_range(1024)),
                 $urandom_range(1048576),
                 $signed($urandom_range(4096 * 256)) - 2048,
                 (ph % 3 == 0) ? $urandom_range(255) : $urandom_range(40 * 256),
                 (ph % 4 == 1) ? 0 : ((ph % 4 == 2) ? $urandom_range(1, 255) :
                                                      $urandom_range(1, 30 * 256)),
                 $urandom_range(1), $urandom_range(1));
      push_random(165);
      drain();
    end

    $display("checked %0d voxels over directed cases and 12 random sphere settings",
             n_checked);
    $display("including hard edges, inverted and 2D masks, and back-pressure");
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// File: spherical_soft_mask.f
hdl/ssm_pkg.sv
hdl/ssm_channels.sv
hdl/ssm_isqrt.sv
hdl/ssm_div.sv
hdl/spherical_soft_mask.sv
dv/ssm_tb_channels.sv
dv/testbench.sv
